### rtl/weighted_least_load_worker_picker_unit_macros.svh
// Assertion helpers for the worker picker.
// Each macro takes a label, clock, active-low reset, checked expression and message.
`ifndef WEIGHTED_LEAST_LOAD_WORKER_PICKER_UNIT_MACROS_SVH
`define WEIGHTED_LEAST_LOAD_WORKER_PICKER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define WLLWP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WLLWP_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define WLLWP_ASSERT(label, clk, rst_n, prop, msg)
`define WLLWP_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

### rtl/wllwp_pkg.sv
package wllwp_pkg;

	localparam int NUM_WORKERS_DEF = 16;
	localparam int TOTAL_WIDTH_DEF = 32;
	localparam int CUR_W           = 16;
	localparam int ACTIVE_W        = 5;
	localparam int REQ_W           = 2;
	localparam int ID_W            = 4;

	localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 5'd1;

	localparam logic [REQ_W-1:0] REQ_PICK   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_ADD    = 2'd1;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic [ID_W-1:0]  worker_id;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0] selected_worker;
		logic            accepted;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic rd_en;   // read the entry at the address
		logic scan;    // the read feeds the minimum search
		logic first;   // first entry of a search
		logic wr_en;   // write back the updated entry
		logic op_add;  // update is an add, else a remove
	} dp_cmd_t;

endpackage

### rtl/weighted_least_load_worker_picker_unit.sv
// Pick, n = effective active workers: after the start beat, scan n slots, drain the pipe, strobe.
// Add or remove in range: read, write, strobe; out of range or unused code: just the strobe.
// Throughput: a new beat is taken in the strobe cycle; a pick is bound by one table read per cycle.
// Reset: all counts read as zero (per-entry valid flags clear at once), active_workers is 1.
// No clearing pass; the receiver cannot stall, each result is shown for one cycle only.
`include "weighted_least_load_worker_picker_unit_macros.svh"

module weighted_least_load_worker_picker_unit #(
	parameter int NUM_WORKERS = wllwp_pkg::NUM_WORKERS_DEF,
	parameter int TOTAL_WIDTH = wllwp_pkg::TOTAL_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  wllwp_pkg::req_t                req,
	output logic                           busy,
	output logic                           done,
	output wllwp_pkg::rsp_t                rsp,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [wllwp_pkg::ACTIVE_W-1:0] cfg_data
);

	// address width of the count table; keep one bit for a single-slot build
	localparam int AW = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;

	wllwp_pkg::dp_cmd_t cmd;
	logic [AW-1:0]      addr;
	logic               pipe_busy;
	logic [AW-1:0]      best;

	// Controller: takes the request beat, holds the active count, sequences the
	// read-modify-write of an update or the scan of a pick, and registers the result.
	wllwp_ctrl #(
		.NUM_WORKERS(NUM_WORKERS),
		.AW(AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.addr      (addr),
		.pipe_busy (pipe_busy),
		.best      (best)
	);

	// Datapath: count table with registered read, saturating update, and a
	// three-stage pipe (read, weight 7*current + 3*total, compare) for the search.
	wllwp_dpath #(
		.NUM_WORKERS(NUM_WORKERS),
		.TOTAL_WIDTH(TOTAL_WIDTH),
		.AW(AW)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.addr      (addr),
		.pipe_busy (pipe_busy),
		.best      (best)
	);

	// the strobe comes only once the controller is back in idle
	`WLLWP_ASSERT(a_done_idle, clk, arst_n, done |-> !busy, "result strobe while busy")
	// an accepted beat always occupies the block for the next cycle
	`WLLWP_ASSERT(a_accept_busy, clk, arst_n, (start && !busy) |=> busy, "beat taken, not busy")
	// each beat gives one strobe, never two in a row
	`WLLWP_ASSERT(a_single_strobe, clk, arst_n, done |=> !done, "result strobe repeated")
	// a rejected request reports slot zero
	`WLLWP_NEVER(a_reject_zero, clk, arst_n, done && !rsp.accepted && rsp.selected_worker != '0,
		"rejected request with non-zero worker")

endmodule

### rtl/wllwp_dpath.sv
module wllwp_dpath #(
	parameter int NUM_WORKERS = wllwp_pkg::NUM_WORKERS_DEF,
	parameter int TOTAL_WIDTH = wllwp_pkg::TOTAL_WIDTH_DEF,
	parameter int AW          = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  wllwp_pkg::dp_cmd_t    cmd,
	input  logic [AW-1:0]         addr,
	output logic                  pipe_busy,
	output logic [AW-1:0]         best
);

	localparam int CW = wllwp_pkg::CUR_W;
	localparam int WB = (TOTAL_WIDTH + 2 > CW + 3) ? TOTAL_WIDTH + 2 : CW + 3;
	localparam int WW = WB + 1;

	logic [CW-1:0]          cur_mem [NUM_WORKERS];
	logic [TOTAL_WIDTH-1:0] tot_mem [NUM_WORKERS];
	logic [NUM_WORKERS-1:0] ent_vld_q;

	logic [CW-1:0]          rd_cur_s1;
	logic [TOTAL_WIDTH-1:0] rd_tot_s1;
	logic                   rd_hit_s1;
	logic                   vld_s1;
	logic                   first_s1;
	logic [AW-1:0]          idx_s1;

	logic [WW-1:0]          wt_s2;
	logic                   vld_s2;
	logic                   first_s2;
	logic [AW-1:0]          idx_s2;

	logic [WW-1:0]          best_w_q;
	logic [AW-1:0]          best_q;

	logic [CW-1:0]          cur_v;
	logic [TOTAL_WIDTH-1:0] tot_v;
	logic [CW-1:0]          new_cur;
	logic [TOTAL_WIDTH-1:0] new_tot;
	logic [WW-1:0]          cur7;
	logic [WW-1:0]          tot3;

	// an entry never written reads as zero
	assign cur_v = rd_hit_s1 ? rd_cur_s1 : '0;
	assign tot_v = rd_hit_s1 ? rd_tot_s1 : '0;

	always_comb begin
		if (cmd.op_add) begin
			new_cur = (cur_v == '1) ? cur_v : cur_v + CW'(1);
			new_tot = (tot_v == '1) ? tot_v : tot_v + TOTAL_WIDTH'(1);
		end else begin
			new_cur = (cur_v == '0) ? cur_v : cur_v - CW'(1);
			new_tot = tot_v;
		end
	end

	assign cur7 = (WW'(cur_v) << 3) - WW'(cur_v);
	assign tot3 = (WW'(tot_v) << 1) + WW'(tot_v);

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			cur_mem[addr] <= new_cur;
			tot_mem[addr] <= new_tot;
		end
		if (cmd.rd_en) begin
			rd_cur_s1 <= cur_mem[addr];
			rd_tot_s1 <= tot_mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
			rd_hit_s1 <= 1'b0;
		end else begin
			if (cmd.wr_en) begin
				ent_vld_q[addr] <= 1'b1;
			end
			if (cmd.rd_en) begin
				rd_hit_s1 <= ent_vld_q[addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.rd_en & cmd.scan;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= cmd.first;
		idx_s1   <= addr;
		first_s2 <= first_s1;
		idx_s2   <= idx_s1;
		wt_s2    <= cur7 + tot3;
	end

	// strict less-than keeps the lowest-numbered slot on a tie
	always_ff @(posedge clk) begin
		if (vld_s2 && (first_s2 || wt_s2 < best_w_q)) begin
			best_w_q <= wt_s2;
			best_q   <= idx_s2;
		end
	end

	assign pipe_busy = vld_s1 | vld_s2;
	assign best      = best_q;

endmodule

### rtl/wllwp_ctrl.sv
module wllwp_ctrl #(
	parameter int NUM_WORKERS = wllwp_pkg::NUM_WORKERS_DEF,
	parameter int AW          = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  wllwp_pkg::req_t                req,
	output logic                           busy,
	output logic                           done,
	output wllwp_pkg::rsp_t                rsp,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [wllwp_pkg::ACTIVE_W-1:0] cfg_data,
	output wllwp_pkg::dp_cmd_t             cmd,
	output logic [AW-1:0]                  addr,
	input  logic                           pipe_busy,
	input  logic [AW-1:0]                  best
);

	localparam int NA = wllwp_pkg::ACTIVE_W;
	localparam int NMAX = (NUM_WORKERS < 31) ? NUM_WORKERS : 31;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RD    = 3'd1;
	localparam logic [2:0] S_WR    = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_DRAIN = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]                     state_q;
	logic [NA-1:0]                  active_q;
	logic [NA-1:0]                  n_eff;
	logic [NA-1:0]                  idx_q;
	logic [wllwp_pkg::REQ_W-1:0]    req_q;
	logic [wllwp_pkg::ID_W-1:0]     wid_q;
	logic                           acc_q;
	logic                           done_q;
	wllwp_pkg::rsp_t                rsp_q;

	always_comb begin
		if (active_q == '0) begin
			n_eff = NA'(1);
		end else if (active_q > NA'(NMAX)) begin
			n_eff = NA'(NMAX);
		end else begin
			n_eff = active_q;
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= wllwp_pkg::ACTIVE_RST;
		end else if (cfg_valid && cfg_ready) begin
			active_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			req_q   <= wllwp_pkg::REQ_PICK;
			wid_q   <= '0;
			acc_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q <= req.req_type;
						wid_q <= req.worker_id;
						idx_q <= '0;
						unique case (req.req_type)
							wllwp_pkg::REQ_PICK: begin
								acc_q   <= 1'b1;
								state_q <= S_SCAN;
							end
							wllwp_pkg::REQ_ADD, wllwp_pkg::REQ_REMOVE: begin
								if (NA'(req.worker_id) < n_eff) begin
									acc_q   <= 1'b1;
									state_q <= S_RD;
								end else begin
									acc_q   <= 1'b0;
									state_q <= S_DONE;
								end
							end
							default: begin
								acc_q   <= 1'b0;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_RD: begin
					state_q <= S_WR;
				end
				S_WR: begin
					state_q <= S_DONE;
				end
				S_SCAN: begin
					idx_q <= idx_q + NA'(1);
					if (idx_q == n_eff - NA'(1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!pipe_busy) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE) begin
			rsp_q.accepted        <= acc_q;
			rsp_q.selected_worker <= (req_q == wllwp_pkg::REQ_PICK && acc_q) ?
				wllwp_pkg::ID_W'(best) : '0;
		end
	end

	always_comb begin
		cmd        = '0;
		cmd.op_add = (req_q == wllwp_pkg::REQ_ADD);
		addr       = AW'(wid_q);
		unique case (state_q)
			S_RD: begin
				cmd.rd_en = 1'b1;
			end
			S_WR: begin
				cmd.wr_en = 1'b1;
			end
			S_SCAN: begin
				cmd.rd_en = 1'b1;
				cmd.scan  = 1'b1;
				cmd.first = (idx_q == '0);
				addr      = AW'(idx_q);
			end
			default: begin
				cmd.rd_en = 1'b0;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

### dv/weighted_least_load_worker_picker_unit_tb.sv
`timescale 1ns / 100ps

module weighted_least_load_worker_picker_unit_tb;

	// request code the block leaves unused: no state change, nothing accepted
	localparam logic [wllwp_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

	// load weight = current * 7 + lifetime total * 3
	localparam int unsigned CUR_FACTOR   = 7;
	localparam int unsigned TOTAL_FACTOR = 3;

	// worst case is a pick over all slots; allow a margin on top
	localparam int unsigned SETTLE_CYCLES = 30;
	// some 1500 beats, gaps and drains included
	localparam int unsigned CYCLE_LIMIT   = 400_000;
	localparam int unsigned BURST_BEATS   = 12;
	localparam int unsigned PHASE_BEATS   = 145;

	// Shadow copy of the per-slot counts, the active-slot register and the queue of
	// responses that the accepted beats still owe.
	class worker_load_ledger;
		bit [wllwp_pkg::CUR_W-1:0]           cur_count   [wllwp_pkg::NUM_WORKERS_DEF];
		bit [wllwp_pkg::TOTAL_WIDTH_DEF-1:0] total_count [wllwp_pkg::NUM_WORKERS_DEF];
		bit [wllwp_pkg::ACTIVE_W-1:0]        active_workers = wllwp_pkg::ACTIVE_RST;
		wllwp_pkg::rsp_t                     owed_rsp_q [$];
		int unsigned                         mismatch_count = 0;

		function int unsigned active_span();
			int unsigned n;
			n = active_workers;
			if (n == 0)
				n = 1;
			if (n > wllwp_pkg::NUM_WORKERS_DEF)
				n = wllwp_pkg::NUM_WORKERS_DEF;
			return n;
		endfunction

		function bit [39:0] load_weight(int unsigned slot);
			return 40'(cur_count[slot]) * 40'(CUR_FACTOR) +
				40'(total_count[slot]) * 40'(TOTAL_FACTOR);
		endfunction

		function void set_active(bit [wllwp_pkg::ACTIVE_W-1:0] v);
			active_workers = v;
		endfunction

		function int unsigned pending();
			return owed_rsp_q.size();
		endfunction

		function void note_request(wllwp_pkg::req_t beat);
			wllwp_pkg::rsp_t owed;
			int unsigned     span;
			int unsigned     best;
			bit [39:0]       best_w;
			bit [39:0]       w;
			owed = '0;
			span = active_span();
			case (beat.req_type)
				wllwp_pkg::REQ_PICK: begin
					// strict less-than keeps the lowest-numbered slot on a tie
					best   = 0;
					best_w = load_weight(0);
					for (int unsigned i = 1; i < span; i++) begin
						w = load_weight(i);
						if (w < best_w) begin
							best   = i;
							best_w = w;
						end
					end
					owed.selected_worker = best[wllwp_pkg::ID_W-1:0];
					owed.accepted        = 1'b1;
				end
				wllwp_pkg::REQ_ADD, wllwp_pkg::REQ_REMOVE: begin
					if (beat.worker_id < span) begin
						if (beat.req_type == wllwp_pkg::REQ_ADD) begin
							if (cur_count[beat.worker_id] != '1)
								cur_count[beat.worker_id]++;
							if (total_count[beat.worker_id] != '1)
								total_count[beat.worker_id]++;
						end else if (cur_count[beat.worker_id] != '0) begin
							cur_count[beat.worker_id]--;
						end
						owed.accepted = 1'b1;
					end
				end
				default: ;
			endcase
			owed_rsp_q = {owed_rsp_q, owed};
		endfunction

		function void check_response(wllwp_pkg::rsp_t got);
			wllwp_pkg::rsp_t want;
			if (owed_rsp_q.size() == 0) begin
				$error("response with no request outstanding: selected_worker %0d accepted %0d",
					got.selected_worker, got.accepted);
				mismatch_count++;
				return;
			end
			want = owed_rsp_q.pop_front();
			if (got.selected_worker !== want.selected_worker) begin
				$error("selected_worker: expected %0d, actual %0d",
					want.selected_worker, got.selected_worker);
				mismatch_count++;
			end
			if (got.accepted !== want.accepted) begin
				$error("accepted: expected %0d, actual %0d", want.accepted, got.accepted);
				mismatch_count++;
			end
		endfunction
	endclass

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           start     = 1'b0;
	wllwp_pkg::req_t                req       = '0;
	logic                           cfg_valid = 1'b0;
	logic [wllwp_pkg::ACTIVE_W-1:0] cfg_data  = '0;
	logic                           busy;
	logic                           done;
	wllwp_pkg::rsp_t                rsp;
	logic                           cfg_ready;

	worker_load_ledger ledger;
	int unsigned       cycle_count = 0;
	int unsigned       idle_style  = 0;

	weighted_least_load_worker_picker_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Watch both channels at every edge. Check a strobed response before noting a
	// beat taken at the same edge: the response always belongs to an older beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				ledger.check_response(rsp);
			if (start && !busy)
				ledger.note_request(req);
			if (cfg_valid && cfg_ready)
				ledger.set_active(cfg_data);
		end
	end

	// Hard stop in case the block hangs or drops a handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Idle gap before the next beat; style 0 gives back-to-back beats, style 2 is
	// mostly tight with the odd long gap, anything else spreads 0..19 evenly.
	function automatic int unsigned draw_gap();
		case (idle_style)
			0:       return 0;
			2:       return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
			default: return $urandom_range(0, 19);
		endcase
	endfunction

	// Present one beat after the given gap and hold it until taken. Leave start
	// high on return so that a following zero-gap beat needs no new edge on it.
	task automatic send_request(input logic [wllwp_pkg::REQ_W-1:0] kind,
			input logic [wllwp_pkg::ID_W-1:0] id, input int unsigned gap);
		wllwp_pkg::req_t beat;
		beat.req_type  = kind;
		beat.worker_id = id;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= beat;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Drop start and hold off until every owed response has come back. Only call
	// straight after send_request, so start sees one assignment per step.
	task automatic drain_responses();
		start <= 1'b0;
		@(posedge clk);
		while (ledger.pending() != 0) @(posedge clk);
	endtask

	// Write the active-slot register; only ever called with the block idle.
	task automatic write_active(input logic [wllwp_pkg::ACTIVE_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly in-range updates so the counts build up and picks have real choices;
	// the rest aim anywhere in the id field or use the unused code.
	task automatic random_request();
		int unsigned                 roll;
		int unsigned                 span;
		logic [wllwp_pkg::REQ_W-1:0] kind;
		logic [wllwp_pkg::ID_W-1:0]  id;
		roll = $urandom_range(0, 99);
		if (roll < 30)
			kind = wllwp_pkg::REQ_PICK;
		else if (roll < 68)
			kind = wllwp_pkg::REQ_ADD;
		else if (roll < 95)
			kind = wllwp_pkg::REQ_REMOVE;
		else
			kind = REQ_UNUSED;
		span = ledger.active_span();
		if ($urandom_range(0, 9) < 8)
			id = wllwp_pkg::ID_W'($urandom_range(0, span - 1));
		else
			id = wllwp_pkg::ID_W'($urandom_range(0, 15));
		send_request(kind, id, draw_gap());
	endtask

	initial begin
		logic [wllwp_pkg::ACTIVE_W-1:0] phase_active [10];
		int unsigned                    failures;
		ledger = new;
		phase_active = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'd7, 5'd16, 5'd0, 5'd2, 5'd12};
		phase_active[7] = wllwp_pkg::ACTIVE_W'($urandom_range(0, 31));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset value of one slot, out-of-range update, remove at zero,
		// unused code, zero-weight ties, then a zero register and an oversize one.
		send_request(wllwp_pkg::REQ_PICK, 4'd0, 0);
		send_request(wllwp_pkg::REQ_ADD, 4'd0, 0);
		send_request(wllwp_pkg::REQ_ADD, 4'd1, 0);
		send_request(wllwp_pkg::REQ_REMOVE, 4'd0, 0);
		send_request(wllwp_pkg::REQ_REMOVE, 4'd0, 0);
		send_request(REQ_UNUSED, 4'd15, 0);
		send_request(wllwp_pkg::REQ_PICK, 4'd15, 0);
		drain_responses();
		write_active(5'd16);
		send_request(wllwp_pkg::REQ_ADD, 4'd15, 0);
		send_request(wllwp_pkg::REQ_ADD, 4'd15, 0);
		send_request(wllwp_pkg::REQ_ADD, 4'd0, 0);
		send_request(wllwp_pkg::REQ_PICK, 4'd0, 0);
		send_request(wllwp_pkg::REQ_ADD, 4'd1, 0);
		send_request(wllwp_pkg::REQ_ADD, 4'd2, 0);
		send_request(wllwp_pkg::REQ_PICK, 4'd0, 0);
		send_request(wllwp_pkg::REQ_REMOVE, 4'd15, 0);
		send_request(wllwp_pkg::REQ_REMOVE, 4'd15, 0);
		send_request(wllwp_pkg::REQ_REMOVE, 4'd15, 0);
		send_request(wllwp_pkg::REQ_PICK, 4'd0, 0);
		drain_responses();
		write_active(5'd0);
		send_request(wllwp_pkg::REQ_PICK, 4'd9, 0);
		send_request(wllwp_pkg::REQ_ADD, 4'd1, 0);
		send_request(wllwp_pkg::REQ_ADD, 4'd0, 0);
		send_request(wllwp_pkg::REQ_PICK, 4'd0, 0);
		drain_responses();
		write_active(5'd31);
		send_request(wllwp_pkg::REQ_ADD, 4'd15, 0);
		send_request(wllwp_pkg::REQ_REMOVE, 4'd14, 0);
		send_request(wllwp_pkg::REQ_PICK, 4'd0, 0);
		drain_responses();

		// Random phases, one register setting each, changed only once drained.
		foreach (phase_active[p]) begin
			write_active(phase_active[p]);
			idle_style = p % 3;
			repeat (PHASE_BEATS) begin
				random_request();
				// now and then hold the sender back until the block has caught up
				if ($urandom_range(0, 59) == 0)
					drain_responses();
			end
			drain_responses();
		end

		// Closing burst: pile adds onto one slot back to back, then pick around it.
		write_active(5'd16);
		repeat (BURST_BEATS) send_request(wllwp_pkg::REQ_ADD, 4'd9, 0);
		send_request(wllwp_pkg::REQ_PICK, 4'd0, 0);
		send_request(wllwp_pkg::REQ_REMOVE, 4'd9, 0);
		send_request(wllwp_pkg::REQ_ADD, 4'd9, 0);
		send_request(wllwp_pkg::REQ_ADD, 4'd9, 0);
		send_request(wllwp_pkg::REQ_PICK, 4'd0, 0);
		drain_responses();

		// Give any stray strobe time to show up before the verdict.
		repeat (SETTLE_CYCLES) @(posedge clk);
		failures = ledger.mismatch_count;
		if (ledger.pending() != 0) begin
			$error("%0d responses never arrived", ledger.pending());
			failures += ledger.pending();
		end
		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/wllwp_pkg.sv
rtl/wllwp_dpath.sv
rtl/wllwp_ctrl.sv
rtl/weighted_least_load_worker_picker_unit.sv
dv/weighted_least_load_worker_picker_unit_tb.sv
